@@ design/aes_pkg.sv @@
// aes-128 package: s-box tables, gf helpers and round functions
// shared by the cipher top level and the key expansion module
package aes_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    localparam logic [7:0] FwdSbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] InvSbox [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] Rcon [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] GfPoly = 8'h1b;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
    endfunction

    function automatic t_word sbox_word(input t_word w);
        return {FwdSbox[w[31:24]], FwdSbox[w[23:16]], FwdSbox[w[15:8]], FwdSbox[w[7:0]]};
    endfunction

    // byte k of the block sits at bits 127-8k .. 120-8k, row k%4, column k/4
    function automatic logic [7:0] get_byte(input t_block s, input int k);
        return s[127 - 8*k -: 8];
    endfunction

    function automatic t_block sbox_block(input t_block s, input logic inv);
        t_block t;
        for (int k = 0; k < 16; k++) begin
            t[127 - 8*k -: 8] = inv ? InvSbox[get_byte(s, k)] : FwdSbox[get_byte(s, k)];
        end
        return t;
    endfunction

    function automatic t_block rotate_rows(input t_block s, input logic inv);
        t_block t;
        int src;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c - r + 4) % 4) : ((c + r) % 4);
                t[127 - 8*(r + 4*c) -: 8] = get_byte(s, r + 4*src);
            end
        end
        return t;
    endfunction

    function automatic t_word mix_col_fwd(input t_word w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix as a pre-multiply by {05,00,04,00}-style step then forward mix
    function automatic t_word mix_col_inv(input t_word w);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    function automatic t_block mix_block(input t_block s, input logic inv);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            t[127 - 32*c -: 32] = inv ? mix_col_inv(s[127 - 32*c -: 32])
                                      : mix_col_fwd(s[127 - 32*c -: 32]);
        end
        return t;
    endfunction

    function automatic t_block next_round_key(input t_block k, input logic [7:0] rc);
        t_word w0, w1, w2, w3;
        w0 = k[127:96] ^ sbox_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

@@ design/aes_key_sched.sv @@
// aes-128 key schedule: registered round keys rebuilt from the key registers
// depends on aes_pkg; one expansion step per register stage
module aes_key_sched import aes_pkg::*; (
    input  logic   i_clk,
    input  t_block i_key,
    output t_block o_rkey [NumRounds + 1]
);

    t_block r_key [NumRounds + 1];

    // a new key ripples one stage per cycle; the top level holds off input until it settles
    always_ff @(posedge i_clk) begin
        r_key[0] <= i_key;
        for (int i = 0; i < NumRounds; i++) begin
            r_key[i + 1] <= next_round_key(r_key[i], Rcon[i]);
        end
    end

    assign o_rkey = r_key;

endmodule

@@ design/aes128_block_cipher.sv @@
// aes-128 encrypt/decrypt, fully unrolled pipeline: add-key stage, then one round per stage
// eleven register stages, r_st[0] through r_st[10], from the input port to the output port
// throughput one word per cycle; a stalled output word holds the whole pipe
// input held off after a key write or reset while the key schedule refills
// i_rst_n synchronous active low: clears stage valid bits and keys to zero
module aes128_block_cipher import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // data_high[63:0], data_low[127:64]
    input  logic         s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // result_high[63:0], result_low[127:64]
);

    localparam int NumStages = NumRounds + 1;
    localparam logic KeyHighIdx = 1'b0;
    localparam logic [3:0] KeySettle = 4'(NumStages);

    logic [63:0] r_key_high, r_key_low;
    logic [3:0]  r_key_wait;
    t_block      rkey [NumRounds + 1];

    logic   r_vld  [NumStages];
    logic   r_dec  [NumStages];
    t_block r_st   [NumStages];
    logic   advance;
    logic   in_take;
    t_block in_blk;

    // index 0 is key_high, index 1 is key_low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == KeyHighIdx) r_key_high <= i_cfg_data;
            else                           r_key_low  <= i_cfg_data;
        end
    end

    // cycles left until every round key reflects the key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_key_wait <= KeySettle;
        end else if (r_key_wait != 4'd0) begin
            r_key_wait <= r_key_wait - 4'd1;
        end
    end

    aes_key_sched u_key_sched (
        .i_clk  (i_clk),
        .i_key  ({r_key_high, r_key_low}),
        .o_rkey (rkey)
    );

    // whole pipe stalls together when the last stage holds an untaken word
    assign advance       = !r_vld[NumStages - 1] || m_axis_tready;
    assign s_axis_tready = advance && (r_key_wait == 4'd0) && !i_cfg_we;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // block byte 0 is the top byte of data_high
    assign in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    function automatic t_block round_fn(input t_block s, input logic dec, input int rnd);
        t_block t;
        if (!dec) begin
            t = rotate_rows(sbox_block(s, 1'b0), 1'b0);
            if (rnd < NumRounds) t = mix_block(t, 1'b0);
            t = t ^ rkey[rnd];
        end else begin
            t = sbox_block(rotate_rows(s, 1'b1), 1'b1) ^ rkey[NumRounds - rnd];
            if (rnd < NumRounds) t = mix_block(t, 1'b1);
        end
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumStages; i++) r_vld[i] <= 1'b0;
        end else if (advance) begin
            r_vld[0] <= in_take;
            for (int i = 1; i < NumStages; i++) r_vld[i] <= r_vld[i - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_dec[0] <= s_axis_tuser;
            r_st[0]  <= in_blk ^ (s_axis_tuser ? rkey[NumRounds] : rkey[0]);
            for (int i = 1; i < NumStages; i++) begin
                r_dec[i] <= r_dec[i - 1];
                r_st[i]  <= round_fn(r_st[i - 1], r_dec[i - 1], i);
            end
        end
    end

    assign m_axis_tvalid = r_vld[NumStages - 1];
    assign m_axis_tdata  = {r_st[NumStages - 1][63:0], r_st[NumStages - 1][127:64]};

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && r_key_wait == 4'd0 && !i_cfg_we |-> s_axis_tready)
        else $error("input blocked while output empty");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted word lost at entry stage");
`endif

endmodule

@@ tb/tb_top.sv @@
// testbench for aes128_block_cipher: known vectors, then randomized blocks under several keys
// every word is checked against a known result or a behavioral aes-128 model kept here; needs aes_pkg
`timescale 1ns / 1ps

module tb_top;
    import aes_pkg::*;

    typedef struct {
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        t_mode        mode;
        logic [127:0] blk;
        bit           known;
        logic [127:0] result;
    } t_vector;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // data_high[63:0], data_low[127:64]
    logic         s_axis_tuser = 1'b0; // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // result_high[63:0], result_low[127:64]

    aes128_block_cipher dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0]  cur_key_hi, cur_key_lo;
    logic [31:0]  key_sched [44];
    logic [127:0] expected_blocks [$];
    int           errors = 0;
    int           blocks_out = 0;
    bit           src_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        key_sched[0] = cur_key_hi[63:32];
        key_sched[1] = cur_key_hi[31:0];
        key_sched[2] = cur_key_lo[63:32];
        key_sched[3] = cur_key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = key_sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {FwdSbox[t[31:24]], FwdSbox[t[23:16]], FwdSbox[t[15:8]], FwdSbox[t[7:0]]}
                    ^ {rc, 24'h0};
                rc = gf_mult(rc, 8'h02);
            end
            key_sched[i] = key_sched[i-4] ^ t;
        end
    endfunction

    // column c is one 32-bit slice with row 0 on top, so round keys line up directly
    function automatic logic [127:0] rkey_at(input int r);
        return {key_sched[4*r], key_sched[4*r+1], key_sched[4*r+2], key_sched[4*r+3]};
    endfunction

    function automatic logic [127:0] cipher_block(input t_mode mode, input logic [127:0] blk);
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  coef [4];
        logic [7:0]  acc;
        logic [127:0] res;
        logic [127:0] rk;
        bit          dec;
        int          rnd;
        dec = (mode == MODE_DEC);
        if (dec) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        blk ^= rkey_at(dec ? NumRounds : 0);
        for (int k = 0; k < 16; k++) st[k] = blk[127 - 8*k -: 8];
        for (int step = 1; step <= NumRounds; step++) begin
            rnd = dec ? NumRounds - step : step;
            rk = rkey_at(rnd);
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    tmp[r + 4*c] = st[r + 4*(dec ? ((c - r + 4) % 4) : ((c + r) % 4))];
            for (int k = 0; k < 16; k++) st[k] = dec ? InvSbox[tmp[k]] : FwdSbox[tmp[k]];
            // decrypt adds the key before mixing, encrypt after
            if (dec)
                for (int k = 0; k < 16; k++) st[k] ^= rk[127 - 8*k -: 8];
            if (step < NumRounds) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                            acc ^= gf_mult(coef[(k - r + 4) % 4], st[k + 4*c]);
                        tmp[r + 4*c] = acc;
                    end
                st = tmp;
            end
            if (!dec)
                for (int k = 0; k < 16; k++) st[k] ^= rk[127 - 8*k -: 8];
        end
        for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = st[k];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %016h expected %016h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 1'b0;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_index <= 1'b1;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_key_hi = hi;
        cur_key_lo = lo;
        build_schedule();
        // let the key schedule registers settle
        repeat (16) @(posedge i_clk);
    endtask

    task automatic send_block(input t_mode mode, input logic [127:0] blk,
                              input bit known, input logic [127:0] result);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(known ? result : cipher_block(mode, blk));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // result check
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            blocks_out++;
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[63:0], 64'h0);
            end else begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64])
                    report_mismatch("result_high", m_axis_tdata[63:0], want[127:64]);
                if (m_axis_tdata[127:64] !== want[63:0])
                    report_mismatch("result_low", m_axis_tdata[127:64], want[63:0]);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off to back up the pipeline
    int sink_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!hold_done && blocks_out >= 100) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] FipsKeyHi = 64'h0001020304050607;
    localparam logic [63:0] FipsKeyLo = 64'h08090a0b0c0d0e0f;

    t_vector directed [] = '{
        '{64'h0, 64'h0, MODE_ENC, 128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{64'h0, 64'h0, MODE_DEC, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1, 128'h0},
        '{64'h0, 64'h0, MODE_ENC, {Ones, Ones}, 0, 128'h0},
        '{64'h0, 64'h0, MODE_DEC, {Ones, Ones}, 0, 128'h0},
        '{64'h0, 64'h0, MODE_ENC, {Ones, 64'h0}, 0, 128'h0},
        '{64'h0, 64'h0, MODE_DEC, {64'h0, Ones}, 0, 128'h0},
        '{64'h0, 64'h0, MODE_ENC, {2{64'ha5a5_5a5a_a5a5_5a5a}}, 0, 128'h0},
        '{Ones, Ones, MODE_ENC, 128'h0, 0, 128'h0},
        '{Ones, Ones, MODE_DEC, {Ones, Ones}, 0, 128'h0},
        '{Ones, Ones, MODE_ENC, {Ones, Ones}, 0, 128'h0},
        '{FipsKeyHi, FipsKeyLo, MODE_ENC, 128'h00112233445566778899aabbccddeeff,
          1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{FipsKeyHi, FipsKeyLo, MODE_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
          1, 128'h00112233445566778899aabbccddeeff},
        '{FipsKeyHi, FipsKeyLo, MODE_ENC, 128'h0, 0, 128'h0},
        '{FipsKeyHi, FipsKeyLo, MODE_DEC, 128'h0, 0, 128'h0}
    };

    logic [63:0] phase_keys [6][2];

    initial begin
        logic [127:0] blk;
        logic [127:0] last_out;
        cur_key_hi = '0;
        cur_key_lo = '0;
        build_schedule();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (16) @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].key_hi !== cur_key_hi || directed[i].key_lo !== cur_key_lo) begin
                drain();
                write_key(directed[i].key_hi, directed[i].key_lo);
            end
            send_block(directed[i].mode, directed[i].blk, directed[i].known,
                       directed[i].result);
        end
        drain();

        phase_keys = '{'{Ones, Ones}, '{{$urandom, $urandom}, {$urandom, $urandom}},
                       '{64'h0, Ones}, '{{$urandom, $urandom}, 64'h0},
                       '{{$urandom, $urandom}, {$urandom, $urandom}},
                       '{{$urandom, $urandom}, {$urandom, $urandom}}};
        for (int ph = 0; ph < 6; ph++) begin
            write_key(phase_keys[ph][0], phase_keys[ph][1]);
            if (ph == 5) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            for (int n = 0; n < 120; n++) begin
                // now and then decrypt a block just encrypted to close the loop
                if (n > 0 && $urandom_range(0, 3) == 0) begin
                    blk = {$urandom, $urandom, $urandom, $urandom};
                    last_out = cipher_block(MODE_ENC, blk);
                    send_block(MODE_ENC, blk, 0, 128'h0);
                    send_block(MODE_DEC, last_out, 1, blk);
                end else begin
                    send_block(t_mode'($urandom_range(0, 1)),
                               {$urandom, $urandom, $urandom, $urandom}, 0, 128'h0);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("aes128_block_cipher regression: pass");
        else
            $display("aes128_block_cipher regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("aes128_block_cipher regression: fail");
        $finish;
    end

endmodule
